FILE: hw/rtl/afu_pkg.sv
// Package for the arithmetic function unit: widths, limits, state codes,
// divider request/response types and the factorial table.
// Depends on nothing; every RTL file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package afu_pkg;

    // Input number width and derived widths
    localparam int N_WIDTH    = 14;
    localparam int ROOT_WIDTH = N_WIDTH / 2 + 1;
    localparam int SQ_WIDTH   = 2 * ROOT_WIDTH;
    localparam int CNT_WIDTH  = $clog2(N_WIDTH + 1);

    // Result field widths
    localparam int TRI_WIDTH  = 15;
    localparam int FACT_WIDTH = 19;
    localparam int SUM_WIDTH  = 16;
    localparam int TOT_WIDTH  = 14;

    // Validity limits (exclusive upper bounds)
    localparam logic [N_WIDTH-1:0] TRI_LIMIT   = N_WIDTH'(200);
    localparam logic [N_WIDTH-1:0] FACT_LIMIT  = N_WIDTH'(10);
    localparam logic [N_WIDTH-1:0] ARITH_LIMIT = N_WIDTH'(10000);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DS_CHECK,
        ST_DS_WAIT,
        ST_PH_CHECK,
        ST_PH_DIVM,
        ST_PH_DIVR,
        ST_PH_FINAL,
        ST_DONE
    } afu_state_t;

    // Divider request and response
    typedef struct packed {
        logic               start;
        logic [N_WIDTH-1:0] dividend;
        logic [N_WIDTH-1:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic               done;
        logic [N_WIDTH-1:0] quotient;
        logic [N_WIDTH-1:0] remainder;
    } div_rsp_t;

    // Factorial of small n; only 1..9 are used
    function automatic logic [FACT_WIDTH-1:0] fact_lookup(input logic [3:0] k);
        logic [FACT_WIDTH-1:0] f;
        case (k)
            4'd1:    f = FACT_WIDTH'(1);
            4'd2:    f = FACT_WIDTH'(2);
            4'd3:    f = FACT_WIDTH'(6);
            4'd4:    f = FACT_WIDTH'(24);
            4'd5:    f = FACT_WIDTH'(120);
            4'd6:    f = FACT_WIDTH'(720);
            4'd7:    f = FACT_WIDTH'(5040);
            4'd8:    f = FACT_WIDTH'(40320);
            4'd9:    f = FACT_WIDTH'(362880);
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/afu_divider.sv
// Restoring divider, one quotient bit per cycle, shared by all phases.
// Depends on afu_pkg for widths and the request/response structs.
`timescale 1ns / 1ps
`default_nettype none

module afu_divider (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire afu_pkg::div_cmd_t cmd,
    output afu_pkg::div_rsp_t      rsp
);
    import afu_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [N_WIDTH-1:0]   rem_reg, rem_next;
    logic [N_WIDTH-1:0]   quo_reg, quo_next;
    logic [N_WIDTH-1:0]   dvs_reg, dvs_next;

    logic [N_WIDTH:0]     shifted;
    logic [N_WIDTH:0]     diff;

    // Trial subtract of the shifted partial remainder
    assign shifted = {rem_reg, quo_reg[N_WIDTH-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    // Step the division
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (busy_reg) begin
            if (!diff[N_WIDTH]) begin
                rem_next = diff[N_WIDTH-1:0];
                quo_next = {quo_reg[N_WIDTH-2:0], 1'b1};
            end else begin
                rem_next = shifted[N_WIDTH-1:0];
                quo_next = {quo_reg[N_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_WIDTH'(1);
            if (cnt_reg == CNT_WIDTH'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (cmd.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_WIDTH'(N_WIDTH);
            rem_next  = '0;
            quo_next  = cmd.dividend;
            dvs_next  = cmd.divisor;
        end
    end

    // Control state takes reset; operands do not
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/arithmetic_function_unit.sv
// Top level of the arithmetic function unit: sequencer, datapath, output register.
// Depends on afu_pkg and afu_divider.
`timescale 1ns / 1ps
`default_nettype none

// Takes one number n per request and returns its triangular number, factorial,
// aliquot sum and Euler totient, each with a valid flag; a value whose flag is
// clear reads zero. Triangular and factorial come out at once; the aliquot sum
// and totient run on one shared restoring divider. The aliquot sum tests
// divisor pairs d, n/d for d up to sqrt(n); the totient factors n by trial
// division up to sqrt(m). For n up to 9999 this is at most about 200
// divisions, far fewer for small n; out-of-range n (zero or 10000 and up)
// skips the divider.
// s_ready is high only while the sequencer is idle; a finished result waits
// in the output register while the next request is accepted.
module arithmetic_function_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [afu_pkg::N_WIDTH-1:0]      s_n,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [afu_pkg::TRI_WIDTH-1:0]         m_triangular,
    output logic                                  m_triangular_valid,
    output logic [afu_pkg::FACT_WIDTH-1:0]        m_factorial,
    output logic                                  m_factorial_valid,
    output logic [afu_pkg::SUM_WIDTH-1:0]         m_divisor_sum,
    output logic                                  m_divisor_sum_valid,
    output logic [afu_pkg::TOT_WIDTH-1:0]         m_totient,
    output logic                                  m_totient_valid
);
    import afu_pkg::*;

    afu_state_t state_reg, state_next;

    logic [N_WIDTH-1:0]    n_reg, n_next;
    logic [ROOT_WIDTH-1:0] d_reg, d_next;
    logic [SUM_WIDTH-1:0]  sum_reg, sum_next;
    logic [N_WIDTH-1:0]    m_reg, m_next;
    logic [N_WIDTH-1:0]    r_reg, r_next;
    logic [ROOT_WIDTH-1:0] p_reg, p_next;
    logic                  found_reg, found_next;
    logic [TRI_WIDTH-1:0]  tri_reg, tri_next;
    logic                  tri_ok_reg, tri_ok_next;
    logic [FACT_WIDTH-1:0] fact_reg, fact_next;
    logic                  fact_ok_reg, fact_ok_next;
    logic                  arith_ok_reg, arith_ok_next;

    logic                  out_valid_reg, out_valid_next;
    logic [TRI_WIDTH-1:0]  out_tri_reg, out_tri_next;
    logic                  out_tri_ok_reg, out_tri_ok_next;
    logic [FACT_WIDTH-1:0] out_fact_reg, out_fact_next;
    logic                  out_fact_ok_reg, out_fact_ok_next;
    logic [SUM_WIDTH-1:0]  out_sum_reg, out_sum_next;
    logic [TOT_WIDTH-1:0]  out_tot_reg, out_tot_next;
    logic                  out_arith_ok_reg, out_arith_ok_next;

    div_cmd_t div_cmd;
    div_rsp_t div_rsp;

    logic                  accept;
    logic                  in_arith_ok;
    logic                  in_tri_ok;
    logic                  in_fact_ok;
    logic [16:0]           tri_prod;
    logic [SQ_WIDTH-1:0]   d_sq;
    logic [SQ_WIDTH-1:0]   p_sq;
    logic                  ds_more;
    logic                  ph_more;
    logic                  div_zero;
    logic                  out_free;
    logic [N_WIDTH-1:0]    d_wide;
    logic [N_WIDTH-1:0]    d_term;
    logic [N_WIDTH-1:0]    q_term;

    afu_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (div_cmd),
        .rsp     (div_rsp)
    );

    // Handshake and range checks on the incoming number
    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign in_arith_ok = (s_n != '0) && (s_n < ARITH_LIMIT);
    assign in_tri_ok   = (s_n != '0) && (s_n < TRI_LIMIT);
    assign in_fact_ok  = (s_n != '0) && (s_n < FACT_LIMIT);
    assign tri_prod    = 17'(s_n[7:0]) * 17'({1'b0, s_n[7:0]} + 9'd1);

    // Loop bounds and divider result tests
    assign d_sq     = SQ_WIDTH'(d_reg) * SQ_WIDTH'(d_reg);
    assign p_sq     = SQ_WIDTH'(p_reg) * SQ_WIDTH'(p_reg);
    assign ds_more  = d_sq <= SQ_WIDTH'(n_reg);
    assign ph_more  = p_sq <= SQ_WIDTH'(m_reg);
    assign div_zero = (div_rsp.remainder == '0);
    assign out_free = !out_valid_reg || m_ready;

    // Divisor pair terms: skip n itself and a repeated square root
    assign d_wide = N_WIDTH'(d_reg);
    assign d_term = (d_wide < n_reg) ? d_wide : '0;
    assign q_term = ((div_rsp.quotient != d_wide) && (div_rsp.quotient < n_reg)) ?
                    div_rsp.quotient : '0;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = in_arith_ok ? ST_DS_CHECK : ST_DONE;
                end
            end
            ST_DS_CHECK: begin
                state_next = ds_more ? ST_DS_WAIT : ST_PH_CHECK;
            end
            ST_DS_WAIT: begin
                if (div_rsp.done) begin
                    state_next = ST_DS_CHECK;
                end
            end
            ST_PH_CHECK: begin
                if (ph_more) begin
                    state_next = ST_PH_DIVM;
                end else if (m_reg > N_WIDTH'(1)) begin
                    state_next = ST_PH_FINAL;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_PH_DIVM: begin
                if (div_rsp.done) begin
                    if (div_zero) begin
                        state_next = ST_PH_DIVM;
                    end else if (found_reg) begin
                        state_next = ST_PH_DIVR;
                    end else begin
                        state_next = ST_PH_CHECK;
                    end
                end
            end
            ST_PH_DIVR: begin
                if (div_rsp.done) begin
                    state_next = ST_PH_CHECK;
                end
            end
            ST_PH_FINAL: begin
                if (div_rsp.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath updates and divider requests
    always_comb begin
        n_next        = n_reg;
        d_next        = d_reg;
        sum_next      = sum_reg;
        m_next        = m_reg;
        r_next        = r_reg;
        p_next        = p_reg;
        found_next    = found_reg;
        tri_next      = tri_reg;
        tri_ok_next   = tri_ok_reg;
        fact_next     = fact_reg;
        fact_ok_next  = fact_ok_reg;
        arith_ok_next = arith_ok_reg;
        div_cmd       = '0;

        out_valid_next    = out_valid_reg;
        out_tri_next      = out_tri_reg;
        out_tri_ok_next   = out_tri_ok_reg;
        out_fact_next     = out_fact_reg;
        out_fact_ok_next  = out_fact_ok_reg;
        out_sum_next      = out_sum_reg;
        out_tot_next      = out_tot_reg;
        out_arith_ok_next = out_arith_ok_reg;

        // Drop a delivered result
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    n_next        = s_n;
                    d_next        = ROOT_WIDTH'(1);
                    sum_next      = '0;
                    m_next        = s_n;
                    r_next        = s_n;
                    p_next        = ROOT_WIDTH'(2);
                    found_next    = 1'b0;
                    tri_ok_next   = in_tri_ok;
                    tri_next      = in_tri_ok ? tri_prod[15:1] : '0;
                    fact_ok_next  = in_fact_ok;
                    fact_next     = in_fact_ok ? fact_lookup(s_n[3:0]) : '0;
                    arith_ok_next = in_arith_ok;
                end
            end
            ST_DS_CHECK: begin
                if (ds_more) begin
                    div_cmd.start    = 1'b1;
                    div_cmd.dividend = n_reg;
                    div_cmd.divisor  = d_wide;
                end
            end
            ST_DS_WAIT: begin
                if (div_rsp.done) begin
                    if (div_zero) begin
                        sum_next = sum_reg + SUM_WIDTH'(d_term) + SUM_WIDTH'(q_term);
                    end
                    d_next = d_reg + ROOT_WIDTH'(1);
                end
            end
            ST_PH_CHECK: begin
                found_next = 1'b0;
                if (ph_more) begin
                    div_cmd.start    = 1'b1;
                    div_cmd.dividend = m_reg;
                    div_cmd.divisor  = N_WIDTH'(p_reg);
                end else if (m_reg > N_WIDTH'(1)) begin
                    div_cmd.start    = 1'b1;
                    div_cmd.dividend = r_reg;
                    div_cmd.divisor  = m_reg;
                end
            end
            ST_PH_DIVM: begin
                if (div_rsp.done) begin
                    if (div_zero) begin
                        // Strip the factor and try it again
                        m_next           = div_rsp.quotient;
                        found_next       = 1'b1;
                        div_cmd.start    = 1'b1;
                        div_cmd.dividend = div_rsp.quotient;
                        div_cmd.divisor  = N_WIDTH'(p_reg);
                    end else if (found_reg) begin
                        div_cmd.start    = 1'b1;
                        div_cmd.dividend = r_reg;
                        div_cmd.divisor  = N_WIDTH'(p_reg);
                    end else begin
                        p_next = p_reg + ROOT_WIDTH'(1);
                    end
                end
            end
            ST_PH_DIVR: begin
                if (div_rsp.done) begin
                    r_next = r_reg - div_rsp.quotient;
                    p_next = p_reg + ROOT_WIDTH'(1);
                end
            end
            ST_PH_FINAL: begin
                if (div_rsp.done) begin
                    r_next = r_reg - div_rsp.quotient;
                end
            end
            ST_DONE: begin
                // Hand the finished request to the output register
                if (out_free) begin
                    out_valid_next    = 1'b1;
                    out_tri_next      = tri_reg;
                    out_tri_ok_next   = tri_ok_reg;
                    out_fact_next     = fact_reg;
                    out_fact_ok_next  = fact_ok_reg;
                    out_sum_next      = arith_ok_reg ? sum_reg : '0;
                    out_tot_next      = arith_ok_reg ? TOT_WIDTH'(r_reg) : '0;
                    out_arith_ok_next = arith_ok_reg;
                end
            end
            default: ;
        endcase
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        n_reg            <= n_next;
        d_reg            <= d_next;
        sum_reg          <= sum_next;
        m_reg            <= m_next;
        r_reg            <= r_next;
        p_reg            <= p_next;
        found_reg        <= found_next;
        tri_reg          <= tri_next;
        tri_ok_reg       <= tri_ok_next;
        fact_reg         <= fact_next;
        fact_ok_reg      <= fact_ok_next;
        arith_ok_reg     <= arith_ok_next;
        out_tri_reg      <= out_tri_next;
        out_tri_ok_reg   <= out_tri_ok_next;
        out_fact_reg     <= out_fact_next;
        out_fact_ok_reg  <= out_fact_ok_next;
        out_sum_reg      <= out_sum_next;
        out_tot_reg      <= out_tot_next;
        out_arith_ok_reg <= out_arith_ok_next;
    end

    // Result channel
    assign m_valid             = out_valid_reg;
    assign m_triangular        = out_tri_reg;
    assign m_triangular_valid  = out_tri_ok_reg;
    assign m_factorial         = out_fact_reg;
    assign m_factorial_valid   = out_fact_ok_reg;
    assign m_divisor_sum       = out_sum_reg;
    assign m_divisor_sum_valid = out_arith_ok_reg;
    assign m_totient           = out_tot_reg;
    assign m_totient_valid     = out_arith_ok_reg;

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Testbench for arithmetic_function_unit: directed and random numbers n, with
// each result checked against a behavioral model of the four functions.
// Depends on afu_pkg and the arithmetic_function_unit RTL.
`timescale 1ns / 1ps

module testbench;

    import afu_pkg::*;

    // Expected output of one request
    typedef struct {
        logic [TRI_WIDTH-1:0]  triangular;
        logic                  triangular_ok;
        logic [FACT_WIDTH-1:0] factorial;
        logic                  factorial_ok;
        logic [SUM_WIDTH-1:0]  divisor_sum;
        logic                  divisor_sum_ok;
        logic [TOT_WIDTH-1:0]  totient;
        logic                  totient_ok;
    } arith_values_t;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [N_WIDTH-1:0]    s_n     = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [TRI_WIDTH-1:0]  m_triangular;
    logic                  m_triangular_valid;
    logic [FACT_WIDTH-1:0] m_factorial;
    logic                  m_factorial_valid;
    logic [SUM_WIDTH-1:0]  m_divisor_sum;
    logic                  m_divisor_sum_valid;
    logic [TOT_WIDTH-1:0]  m_totient;
    logic                  m_totient_valid;

    arith_values_t pending_values[$];
    int unsigned   error_count   = 0;
    bit            source_steady = 1'b0;
    bit            sink_steady   = 1'b0;

    always #2 aclk = ~aclk;

    arithmetic_function_unit u_top (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_n                 (s_n),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_triangular        (m_triangular),
        .m_triangular_valid  (m_triangular_valid),
        .m_factorial         (m_factorial),
        .m_factorial_valid   (m_factorial_valid),
        .m_divisor_sum       (m_divisor_sum),
        .m_divisor_sum_valid (m_divisor_sum_valid),
        .m_totient           (m_totient),
        .m_totient_valid     (m_totient_valid)
    );

    // Compute the four functions of n with their range flags
    function automatic arith_values_t arith_functions(input logic [N_WIDTH-1:0] n);
        arith_values_t r;
        int unsigned   v;
        int unsigned   acc;
        int unsigned   rest;
        int unsigned   p;
        v = 32'(n);
        r = '{default: '0};
        if (v > 0 && v < 200) begin
            r.triangular    = TRI_WIDTH'(v * (v + 1) / 2);
            r.triangular_ok = 1'b1;
        end
        if (v > 0 && v < 10) begin
            acc = 1;
            for (p = 2; p <= v; p++) acc *= p;
            r.factorial    = FACT_WIDTH'(acc);
            r.factorial_ok = 1'b1;
        end
        if (v > 0 && v < 10000) begin
            // proper divisors never exceed n/2
            acc = 0;
            for (p = 1; p <= v / 2; p++) if (v % p == 0) acc += p;
            r.divisor_sum    = SUM_WIDTH'(acc);
            r.divisor_sum_ok = 1'b1;
            // totient by prime factorization; phi(1) = 1
            acc  = v;
            rest = v;
            for (p = 2; p * p <= rest; p++) begin
                if (rest % p == 0) begin
                    while (rest % p == 0) rest /= p;
                    acc -= acc / p;
                end
            end
            if (rest > 1) acc -= acc / rest;
            r.totient    = TOT_WIDTH'(acc);
            r.totient_ok = 1'b1;
        end
        return r;
    endfunction

    // Drive one request, idling at random first, and record its expected result
    task automatic send_number(input logic [N_WIDTH-1:0] n);
        while (!source_steady && $urandom_range(99) < 13) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_n     <= n;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_values.insert(pending_values.size(), arith_functions(n));
    endtask

    // Drop the request line and hold until every expected result has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_values.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [N_WIDTH-1:0] random_number();
        case ($urandom_range(9))
            0, 1, 2, 3: return N_WIDTH'($urandom_range(199, 1));
            4, 5:       return N_WIDTH'($urandom_range(9999, 200));
            6:          return N_WIDTH'($urandom_range(16383, 10000));
            7:          return N_WIDTH'($urandom_range(11));
            default:    return N_WIDTH'($urandom_range(16383));
        endcase
    endfunction

    // Sample the result channel: stall at random unless held steady
    always @(posedge aclk) begin
        m_ready <= sink_steady || ($urandom_range(99) >= 13);
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        arith_values_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_values.size() == 0) begin
                $error("result with no request outstanding");
                error_count++;
            end else begin
                want = pending_values.pop_front();
                check_field("triangular", 32'(want.triangular), 32'(m_triangular));
                check_field("triangular_valid", 32'(want.triangular_ok),
                            32'(m_triangular_valid));
                check_field("factorial", 32'(want.factorial), 32'(m_factorial));
                check_field("factorial_valid", 32'(want.factorial_ok),
                            32'(m_factorial_valid));
                check_field("divisor_sum", 32'(want.divisor_sum), 32'(m_divisor_sum));
                check_field("divisor_sum_valid", 32'(want.divisor_sum_ok),
                            32'(m_divisor_sum_valid));
                check_field("totient", 32'(want.totient), 32'(m_totient));
                check_field("totient_valid", 32'(want.totient_ok),
                            32'(m_totient_valid));
            end
        end
    end

    // Every n with a valid factorial
    task automatic test_factorial_range();
        for (int k = 1; k <= 9; k++) send_number(N_WIDTH'(k));
    endtask

    // Zero, the edges of each valid range and the largest input
    task automatic test_range_edges();
        send_number(N_WIDTH'(0));
        send_number(N_WIDTH'(10));
        send_number(N_WIDTH'(199));
        send_number(N_WIDTH'(200));
        send_number(N_WIDTH'(9999));
        send_number(N_WIDTH'(10000));
        send_number({N_WIDTH{1'b1}});
    endtask

    // Perfect, highly composite and prime numbers, each followed by a wait until the unit has drained
    task automatic test_isolated_numbers();
        send_number(N_WIDTH'(6));
        wait_drained();
        send_number(N_WIDTH'(5040));
        wait_drained();
        send_number(N_WIDTH'(9240));
        wait_drained();
        send_number(N_WIDTH'(9973));
        wait_drained();
    endtask

    // Random numbers with neither side idling
    task automatic test_back_to_back();
        source_steady = 1'b1;
        sink_steady   = 1'b1;
        for (int k = 0; k < 20; k++) send_number(random_number());
        source_steady = 1'b0;
        sink_steady   = 1'b0;
    endtask

    task automatic test_random_numbers();
        for (int k = 0; k < 80; k++) send_number(random_number());
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_factorial_range();
        test_range_edges();
        test_isolated_numbers();
        test_back_to_back();
        test_random_numbers();
        wait_drained();
        repeat (32) @(posedge aclk);
        if (error_count == 0) begin
            $display("arithmetic_function_unit verification clean");
        end else begin
            $display("arithmetic_function_unit verification failed");
        end
        $finish;
    end

    // Abort a hung run
    initial begin
        #20_000_000;
        $display("arithmetic_function_unit verification failed");
        $finish;
    end

endmodule
